[hdl/rgb5a3_pkg.sv]
package rgb5a3_pkg;

	// Image geometry bounds
	localparam int MAX_TILES_PER_SIDE = 256;
	localparam int TILE_CNT_W         = $clog2(MAX_TILES_PER_SIDE);
	localparam int COORD_W            = TILE_CNT_W + 2;
	localparam int CFG_W              = 9;
	localparam int PIX_IDX_W          = 20;
	localparam int TEXEL_W            = 16;
	localparam int PIXEL_W            = 32;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_WIDTH_TILES  = 1'b0,
		CFG_HEIGHT_TILES = 1'b1
	} cfg_reg_t;

	// One classified texel on its way to the back end
	typedef struct packed {
		logic [TEXEL_W-1:0] texel;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [CFG_W-1:0]   w_eff;
		logic               last;
	} texel_item_t;

endpackage

[hdl/rgb5a3_front.sv]
module rgb5a3_front
	import rgb5a3_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [TEXEL_W-1:0] texel,
	input  logic               q_full,
	output logic               push,
	output texel_item_t        push_item
);

	logic [CFG_W-1:0]      width_q;
	logic [CFG_W-1:0]      height_q;
	logic [1:0]            sub_x_q;
	logic [1:0]            sub_y_q;
	logic [TILE_CNT_W-1:0] tile_col_q;
	logic [TILE_CNT_W-1:0] tile_row_q;

	logic [CFG_W-1:0]      w_eff;
	logic [CFG_W-1:0]      h_eff;
	logic [TILE_CNT_W:0]   col_inc;
	logic [TILE_CNT_W:0]   row_inc;
	logic                  tile_done;

	// Clamp a tile count to 1..MAX
	function automatic logic [CFG_W-1:0] clamp_tiles(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] r;
		r = v;
		if (v == '0)
			r = CFG_W'(1);
		else if (v > CFG_W'(MAX_TILES_PER_SIDE))
			r = CFG_W'(MAX_TILES_PER_SIDE);
		return r;
	endfunction

	assign w_eff = clamp_tiles(width_q);
	assign h_eff = clamp_tiles(height_q);

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	assign col_inc   = {1'b0, tile_col_q} + (TILE_CNT_W+1)'(1);
	assign row_inc   = {1'b0, tile_row_q} + (TILE_CNT_W+1)'(1);
	assign tile_done = (sub_x_q == 2'd3) && (sub_y_q == 2'd3);

	// Classify: position and end-of-image flag
	always_comb begin
		push_item.texel = texel;
		push_item.x     = {tile_col_q, sub_x_q};
		push_item.y     = {tile_row_q, sub_y_q};
		push_item.w_eff = w_eff;
		push_item.last  = tile_done &&
			(CFG_W'(tile_col_q) == w_eff - CFG_W'(1)) &&
			(CFG_W'(tile_row_q) == h_eff - CFG_W'(1));
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_WIDTH_TILES:  width_q  <= cfg_data;
				CFG_HEIGHT_TILES: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Tile walk counters, advance once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_x_q    <= '0;
			sub_y_q    <= '0;
			tile_col_q <= '0;
			tile_row_q <= '0;
		end else if (push) begin
			sub_x_q <= sub_x_q + 2'd1;
			if (sub_x_q == 2'd3)
				sub_y_q <= sub_y_q + 2'd1;
			if (tile_done) begin
				if (CFG_W'(col_inc) >= w_eff) begin
					tile_col_q <= '0;
					if (CFG_W'(row_inc) >= h_eff)
						tile_row_q <= '0;
					else
						tile_row_q <= row_inc[TILE_CNT_W-1:0];
				end else begin
					tile_col_q <= col_inc[TILE_CNT_W-1:0];
				end
			end
		end
	end

endmodule

[hdl/rgb5a3_queue.sv]
module rgb5a3_queue
	import rgb5a3_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  texel_item_t push_item,
	output logic        full,
	input  logic        pop,
	output logic        pop_valid,
	output texel_item_t pop_item
);

	texel_item_t       slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = slot_q[rd_ptr_q];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_item;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

[hdl/rgb5a3_back.sv]
module rgb5a3_back
	import rgb5a3_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  texel_item_t          q_item,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PIXEL_W-1:0]   packed_pixel,
	output logic [PIX_IDX_W-1:0] pixel_index,
	output logic                 is_last
);

	// c*255/31 and a*255/7, truncated
	localparam logic [7:0] SCALE5 [32] = '{
		8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
		8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
		8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
		8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
	};
	localparam logic [7:0] SCALE3 [8] = '{
		8'd0, 8'd36, 8'd72, 8'd109, 8'd145, 8'd182, 8'd218, 8'd255
	};

	localparam int PROD_W = COORD_W + CFG_W + 2;

	logic                 valid_q;
	logic [PIXEL_W-1:0]   pixel_q;
	logic [PIX_IDX_W-1:0] index_q;
	logic                 last_q;

	logic                 load;
	logic [PIXEL_W-1:0]   pixel_d;
	logic [PROD_W-1:0]    row_base;
	logic [PROD_W-1:0]    index_full;
	logic [TEXEL_W-1:0]   t;

	assign load = !valid_q || out_ready;
	assign pop  = q_valid && load;
	assign t    = q_item.texel;

	// Color expand; 4-bit channels are c*17
	always_comb begin
		if (t[15]) begin
			pixel_d = {8'hFF, SCALE5[t[14:10]], SCALE5[t[9:5]], SCALE5[t[4:0]]};
		end else begin
			pixel_d = {SCALE3[t[14:12]], t[11:8], t[11:8], t[7:4], t[7:4],
				t[3:0], t[3:0]};
		end
	end

	// Linear index: x + y * 4 * width
	assign row_base   = PROD_W'(q_item.y) * PROD_W'({q_item.w_eff, 2'b00});
	assign index_full = row_base + PROD_W'(q_item.x);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pixel_q <= pixel_d;
			index_q <= index_full[PIX_IDX_W-1:0];
			last_q  <= q_item.last;
		end
	end

	assign out_valid    = valid_q;
	assign packed_pixel = pixel_q;
	assign pixel_index  = index_q;
	assign is_last      = last_q;

endmodule

[hdl/rgb5a3_tiled_texel_decoder.sv]
// Channel   Handshake             Payload
// cfg       cfg_we                cfg_index, cfg_data
// in        in_valid / in_ready   texel
// out       out_valid / out_ready packed_pixel, pixel_index, is_last
//
// One texel per cycle while out_ready is high; output is registered after the queue.
// The front walks the tile counters, a two-entry queue feeds the back end,
// which expands color and forms the index with one 10x11 multiply.
// Reset gives 1x1 tiles and clears counters, queue pointers and output valid.
// in_ready drops only when the queue is full; out stalls back up through the queue.
module rgb5a3_tiled_texel_decoder
	import rgb5a3_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TEXEL_W-1:0]   texel,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PIXEL_W-1:0]   packed_pixel,
	output logic [PIX_IDX_W-1:0] pixel_index,
	output logic                 is_last
);

	logic        push;
	texel_item_t push_item;
	logic        q_full;
	logic        pop;
	logic        q_valid;
	texel_item_t q_item;

	rgb5a3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.texel     (texel),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	rgb5a3_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_item  (q_item)
	);

	rgb5a3_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.packed_pixel (packed_pixel),
		.pixel_index  (pixel_index),
		.is_last      (is_last)
	);

endmodule

[hdl/rgb5a3_checker.sv]
module rgb5a3_checker
	import rgb5a3_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [PIXEL_W-1:0]   packed_pixel,
	input logic [PIX_IDX_W-1:0] pixel_index,
	input logic                 is_last
);

	// Stalled output holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(packed_pixel) &&
			$stable(pixel_index) && $stable(is_last))
		else $error("output changed while stalled");

	// Last texel sits in the right column of a tile
	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_last |-> pixel_index[1:0] == 2'b11)
		else $error("is_last off the tile's right column");

	// Alpha below full means the 4-bit form: each color byte is nibble doubled
	a_rgb444: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && packed_pixel[31:24] != 8'hFF |->
			packed_pixel[23:20] == packed_pixel[19:16] &&
			packed_pixel[15:12] == packed_pixel[11:8] &&
			packed_pixel[7:4] == packed_pixel[3:0])
		else $error("4-bit channel expand mismatch");

endmodule

bind rgb5a3_tiled_texel_decoder rgb5a3_checker u_rgb5a3_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.packed_pixel (packed_pixel),
	.pixel_index  (pixel_index),
	.is_last      (is_last)
);

[dv/rgb5a3_texel_checker.sv]
module rgb5a3_texel_checker
	import rgb5a3_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [TEXEL_W-1:0]   texel,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [PIXEL_W-1:0]   packed_pixel,
	input  logic [PIX_IDX_W-1:0] pixel_index,
	input  logic                 is_last,
	output int                   mismatches,
	output int                   pixels_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [PIXEL_W-1:0]   color;
		logic [PIX_IDX_W-1:0] index;
		logic                 last;
	} pixel_result_t;

	pixel_result_t         due_pixels[$];
	logic [CFG_W-1:0]      width_cfg;
	logic [CFG_W-1:0]      height_cfg;
	logic [1:0]            sub_x;
	logic [1:0]            sub_y;
	logic [TILE_CNT_W-1:0] tile_col;
	logic [TILE_CNT_W-1:0] tile_row;
	int                    errs = 0;

	// Truncating expansion of an n-bit channel to 8 bits
	function automatic logic [7:0] scale_channel(input int c, input int full);
		return 8'((c * 255) / full);
	endfunction

	function automatic logic [PIXEL_W-1:0] expand_rgb5a3(input logic [TEXEL_W-1:0] t);
		logic [7:0] r, g, b, a;
		if (t[15]) begin
			b = scale_channel(t[14:10], 31);
			g = scale_channel(t[9:5], 31);
			r = scale_channel(t[4:0], 31);
			a = 8'hFF;
		end else begin
			a = scale_channel(t[14:12], 7);
			b = scale_channel(t[11:8], 15);
			g = scale_channel(t[7:4], 15);
			r = scale_channel(t[3:0], 15);
		end
		return {a, b, g, r};
	endfunction

	// Zero reads as one tile, anything past the maximum as the maximum
	function automatic int clamp_tiles(input logic [CFG_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_TILES_PER_SIDE)
			return MAX_TILES_PER_SIDE;
		return int'(v);
	endfunction

	function automatic void note_error();
		errs++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t exp_px;
		int w, h, x, y;
		if (!arst_n) begin
			width_cfg  = CFG_W'(1);
			height_cfg = CFG_W'(1);
			sub_x      = '0;
			sub_y      = '0;
			tile_col   = '0;
			tile_row   = '0;
			due_pixels.delete();
			mismatches <= 0;
			pixels_due <= 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_WIDTH_TILES:  width_cfg = cfg_data;
					CFG_HEIGHT_TILES: height_cfg = cfg_data;
					default: ;
				endcase
			end

			// input transaction: predict the pixel, then walk the tile position
			if (in_valid && in_ready) begin
				w = clamp_tiles(width_cfg);
				h = clamp_tiles(height_cfg);
				x = int'(tile_col) * 4 + int'(sub_x);
				y = int'(tile_row) * 4 + int'(sub_y);
				exp_px.color = expand_rgb5a3(texel);
				exp_px.index = PIX_IDX_W'(x + y * 4 * w);
				exp_px.last  = (sub_x == 2'd3) && (sub_y == 2'd3) &&
					(int'(tile_col) == w - 1) && (int'(tile_row) == h - 1);
				due_pixels.push_back(exp_px);

				sub_x = sub_x + 2'd1;
				if (sub_x == 2'd0) begin
					sub_y = sub_y + 2'd1;
					if (sub_y == 2'd0) begin
						// a counter left past a shrunken bound wraps here too
						if (int'(tile_col) + 1 >= w) begin
							tile_col = '0;
							if (int'(tile_row) + 1 >= h)
								tile_row = '0;
							else
								tile_row = tile_row + 1'b1;
						end else begin
							tile_col = tile_col + 1'b1;
						end
					end
				end
			end

			// output transaction: compare against the oldest prediction
			if (out_valid && out_ready) begin
				if (due_pixels.size() == 0) begin
					$display("%0t chk: unexpected pixel %h index %0d last %0b",
						$time, packed_pixel, pixel_index, is_last);
					note_error();
				end else begin
					exp_px = due_pixels.pop_front();
					if (packed_pixel !== exp_px.color) begin
						$display("%0t chk: packed_pixel expected %h actual %h",
							$time, exp_px.color, packed_pixel);
						note_error();
					end
					if (pixel_index !== exp_px.index) begin
						$display("%0t chk: pixel_index expected %0d actual %0d",
							$time, exp_px.index, pixel_index);
						note_error();
					end
					if (is_last !== exp_px.last) begin
						$display("%0t chk: is_last expected %0b actual %0b",
							$time, exp_px.last, is_last);
						note_error();
					end
				end
			end

			mismatches <= errs;
			pixels_due <= due_pixels.size();
		end
	end

endmodule

[dv/rgb5a3_tiled_texel_decoder_test.sv]
module rgb5a3_tiled_texel_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;
	import rgb5a3_pkg::*;

	// Field corners of both texel formats
	localparam logic [TEXEL_W-1:0] CORNER_TEXELS [16] = '{
		16'h8000, 16'hFFFF, 16'h801F, 16'h83E0, 16'hFC00, 16'hD5AA,
		16'h0000, 16'h7FFF, 16'h7000, 16'h0F00, 16'h00F0, 16'h000F,
		16'h1000, 16'h3456, 16'h4BCD, 16'h0001
	};
	localparam int IDLE_PCT      = 18;
	localparam int RANDOM_BUDGET = 650;
	localparam int WIDE_TILES    = 256;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [0:0]           cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [TEXEL_W-1:0]   texel;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [PIXEL_W-1:0]   packed_pixel;
	logic [PIX_IDX_W-1:0] pixel_index;
	logic                 is_last;
	int                   mismatches;
	int                   pixels_due;
	logic                 quiet;
	int                   texels_sent;
	int                   settings_done;

	rgb5a3_tiled_texel_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.texel        (texel),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.packed_pixel (packed_pixel),
		.pixel_index  (pixel_index),
		.is_last      (is_last)
	);

	rgb5a3_texel_checker monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.texel        (texel),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.packed_pixel (packed_pixel),
		.pixel_index  (pixel_index),
		.is_last      (is_last),
		.mismatches   (mismatches),
		.pixels_due   (pixels_due)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// Pixel sink: random back-pressure, none during the quiet stretch
	always @(posedge clk) begin
		out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
	end

	// One texel transaction; valid stays up after acceptance until an idle
	// cycle or the next texel replaces it
	task automatic send_texel(input logic [TEXEL_W-1:0] t);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		texel    <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		texels_sent++;
	endtask

	// Wait until every predicted pixel has come out
	task automatic drain_pixels();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pixels_due != 0)
			@(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_WIDTH_TILES;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= CFG_HEIGHT_TILES;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_done++;
	endtask

	function automatic logic [TEXEL_W-1:0] pick_texel();
		if ($urandom_range(7) == 0)
			return CORNER_TEXELS[$urandom_range(15)];
		return TEXEL_W'($urandom_range(16'hFFFF));
	endfunction

	// Mostly small images, with zero, the maximum and over-range mixed in
	function automatic int pick_tiles();
		case ($urandom_range(9))
			0:       return 0;
			1:       return WIDE_TILES;
			2:       return $urandom_range(257, 511);
			3:       return $urandom_range(5, 255);
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	function automatic int eff_tiles(input int v);
		return (v == 0) ? 1 : ((v > WIDE_TILES) ? WIDE_TILES : v);
	endfunction

	initial begin
		int budget, n, w_val, h_val, area;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_WIDTH_TILES;
		cfg_data      = '0;
		in_valid      = 1'b0;
		texel         = '0;
		quiet         = 1'b0;
		texels_sent   = 0;
		settings_done = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry is one tile: the corners fill exactly one image
		foreach (CORNER_TEXELS[i])
			send_texel(CORNER_TEXELS[i]);
		drain_pixels();

		// zero reads as one tile
		write_cfg('0, '0);
		for (int i = 0; i < 4; i++)
			send_texel(pick_texel());
		drain_pixels();

		// all-ones and over-range both clamp to the maximum, mid-tile
		write_cfg('1, CFG_W'(257));
		for (int i = 0; i < 4; i++)
			send_texel(pick_texel());
		drain_pixels();

		// sixteen tiles along the widest row, no idling on either side;
		// the counters start at row 0, column 0, sub row 2
		quiet = 1'b1;
		write_cfg(CFG_W'(WIDE_TILES), CFG_W'(1));
		for (int i = 0; i < WIDE_TILES; i++)
			send_texel(pick_texel());
		drain_pixels();
		quiet = 1'b0;

		// random geometries; phases end at random points, so many writes
		// land mid-image with counters past the new bound
		budget = 0;
		while (budget < RANDOM_BUDGET) begin
			w_val = pick_tiles();
			h_val = pick_tiles();
			write_cfg(CFG_W'(w_val), CFG_W'(h_val));
			area = eff_tiles(w_val) * eff_tiles(h_val);
			if (area <= 16)
				n = 16 * area * $urandom_range(1, 2) + $urandom_range(0, 20);
			else
				n = $urandom_range(4, 120);
			for (int i = 0; i < n; i++)
				send_texel(pick_texel());
			budget += n;
			drain_pixels();
		end

		repeat (4) @(posedge clk);
		$display("tb: %0d texels sent over %0d register settings (0 to 511 tiles per side)",
			texels_sent, settings_done);
		$display("tb: covered both texel formats, mid-image geometry changes, a wide-row burst");
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[files.f]
hdl/rgb5a3_pkg.sv
hdl/rgb5a3_front.sv
hdl/rgb5a3_queue.sv
hdl/rgb5a3_back.sv
hdl/rgb5a3_tiled_texel_decoder.sv
hdl/rgb5a3_checker.sv
dv/rgb5a3_texel_checker.sv
dv/rgb5a3_tiled_texel_decoder_test.sv
